@@ sv/sspp_pkg.sv @@
package sspp_pkg;

    // Character counter width and its saturation point
    localparam int unsigned POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Data coding scheme for the GSM 7-bit default alphabet
    localparam logic [7:0] DCS_GSM7 = 8'h00;

    // PDU type flag bits
    localparam int unsigned TYPE_SRR_BIT  = 5;
    localparam int unsigned TYPE_UDHI_BIT = 6;

    // One input beat: a hex character and the end-of-PDU flag
    typedef struct packed {
        logic [7:0] hex_char;
        logic       last;
    } t_sspp_in;

    // One result beat
    typedef struct packed {
        logic       valid_res;
        logic [7:0] type_octet;
        logic [7:0] msg_ref;
        logic [7:0] originator_digits;
        logic [7:0] protocol_id;
        logic [7:0] coding_scheme;
        logic [7:0] user_data_length;
        logic       status_report_requested;
        logic       header_present;
    } t_sspp_out;

endpackage

@@ sv/sspp_in_stage.sv @@
module sspp_in_stage
    import sspp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_sspp_in i_data,
    output logic     o_ready,
    output logic     o_item_valid,
    output t_sspp_in o_item,
    input  logic     i_take
);

    logic     r_valid;
    t_sspp_in r_data;

    // Accept a new beat when empty or when the held beat is consumed this cycle
    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_data;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

@@ sv/sspp_parse.sv @@
module sspp_parse
    import sspp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    input  t_sspp_in  i_item,
    input  logic      i_res_space,
    output logic      o_take,
    output logic      o_res_load,
    output t_sspp_out o_res
);

    typedef enum logic [3:0] {
        PH_SCA_LEN,
        PH_SCA_SKIP,
        PH_TYPE,
        PH_MR,
        PH_OA_LEN,
        PH_OA_SKIP,
        PH_PID,
        PH_DCS,
        PH_UDL,
        PH_DATA
    } t_phase;

    t_phase           r_phase, n_phase, w_phase;
    logic [POS_W-1:0] r_pos, n_pos, w_pos;
    logic [POS_W-1:0] r_next, n_next, w_next;
    logic [POS_W-1:0] r_exp, n_exp, w_exp;
    logic [3:0]       r_high, n_high, w_high;
    logic [7:0]       r_type, n_type, w_type;
    logic [7:0]       r_mr, n_mr, w_mr;
    logic [7:0]       r_digits, n_digits, w_digits;
    logic [7:0]       r_pid, n_pid, w_pid;
    logic [7:0]       r_dcs, n_dcs, w_dcs;
    logic [7:0]       r_udl, n_udl, w_udl;
    logic             r_err, n_err, w_err;

    logic [3:0]       w_nib;
    logic             w_hex_ok;
    logic [7:0]       w_octet;
    logic [POS_W-1:0] w_p1;
    logic [8:0]       w_oa_span;
    logic [8:0]       w_ud_span;
    logic             w_valid;

    // Hold a final character while the result register is full
    assign o_take     = i_item_valid && (!i_item.last || i_res_space);
    assign o_res_load = o_take && i_item.last;

    // Decode one ASCII hex digit; a bad character counts as zero
    always_comb begin
        w_nib    = 4'd0;
        w_hex_ok = 1'b1;
        case (i_item.hex_char) inside
            [8'h30:8'h39]: w_nib = i_item.hex_char[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: w_nib = i_item.hex_char[3:0] + 4'd9;
            default:       w_hex_ok = 1'b0;
        endcase
    end

    // Octet and span arithmetic
    assign w_octet   = {r_high, w_nib};
    assign w_p1      = r_pos + POS_W'(1);
    assign w_oa_span = {1'b0, w_octet} + {8'd0, w_octet[0]};
    assign w_ud_span = (r_dcs == DCS_GSM7)
                     ? ({w_octet, 1'b0} - {3'd0, w_octet[7:3], 1'b0})
                     : {w_octet, 1'b0};

    // Advance the parser by one character
    always_comb begin
        w_phase  = r_phase;
        w_pos    = r_pos;
        w_next   = r_next;
        w_exp    = r_exp;
        w_high   = r_high;
        w_type   = r_type;
        w_mr     = r_mr;
        w_digits = r_digits;
        w_pid    = r_pid;
        w_dcs    = r_dcs;
        w_udl    = r_udl;
        w_err    = r_err;
        if (o_take) begin
            if (r_pos == POS_MAX) begin
                w_err = 1'b1;
            end else begin
                w_pos = w_p1;
                case (r_phase)
                    PH_SCA_SKIP: begin
                        if (w_p1 >= r_next) w_phase = PH_TYPE;
                    end
                    PH_OA_SKIP: begin
                        if (w_p1 >= r_next) w_phase = PH_PID;
                    end
                    PH_DATA: begin
                    end
                    default: begin
                        if (!w_hex_ok) w_err = 1'b1;
                        if (!r_pos[0]) begin
                            w_high = w_nib;
                        end else begin
                            case (r_phase)
                                PH_SCA_LEN: begin
                                    if (w_octet == 8'd0) begin
                                        w_phase = PH_TYPE;
                                    end else begin
                                        w_next  = w_p1 + {2'b00, w_octet, 1'b0};
                                        w_phase = PH_SCA_SKIP;
                                    end
                                end
                                PH_TYPE: begin
                                    w_type  = w_octet;
                                    w_phase = PH_MR;
                                end
                                PH_MR: begin
                                    w_mr    = w_octet;
                                    w_phase = PH_OA_LEN;
                                end
                                PH_OA_LEN: begin
                                    w_digits = w_octet;
                                    w_next   = w_p1 + {2'b00, w_oa_span} + POS_W'(2);
                                    w_phase  = PH_OA_SKIP;
                                end
                                PH_PID: begin
                                    w_pid   = w_octet;
                                    w_phase = PH_DCS;
                                end
                                PH_DCS: begin
                                    w_dcs   = w_octet;
                                    w_phase = PH_UDL;
                                end
                                default: begin
                                    w_udl   = w_octet;
                                    w_exp   = w_p1 + {2'b00, w_ud_span};
                                    w_phase = PH_DATA;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    // Build the result from the updated state
    assign w_valid = !w_err && (w_phase == PH_DATA) && (w_pos == w_exp);

    always_comb begin
        o_res.valid_res               = w_valid;
        o_res.type_octet              = w_type;
        o_res.msg_ref                 = w_mr;
        o_res.originator_digits       = w_digits;
        o_res.protocol_id             = w_pid;
        o_res.coding_scheme           = w_dcs;
        o_res.user_data_length        = w_udl;
        o_res.status_report_requested = w_valid && w_type[TYPE_SRR_BIT];
        o_res.header_present          = w_type[TYPE_UDHI_BIT];
    end

    // Return to the start state after the final character
    always_comb begin
        n_phase  = w_phase;
        n_pos    = w_pos;
        n_next   = w_next;
        n_exp    = w_exp;
        n_high   = w_high;
        n_type   = w_type;
        n_mr     = w_mr;
        n_digits = w_digits;
        n_pid    = w_pid;
        n_dcs    = w_dcs;
        n_udl    = w_udl;
        n_err    = w_err;
        if (o_res_load) begin
            n_phase  = PH_SCA_LEN;
            n_pos    = '0;
            n_next   = '0;
            n_exp    = '0;
            n_high   = '0;
            n_type   = '0;
            n_mr     = '0;
            n_digits = '0;
            n_pid    = '0;
            n_dcs    = '0;
            n_udl    = '0;
            n_err    = 1'b0;
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCA_LEN;
            r_pos    <= '0;
            r_next   <= '0;
            r_exp    <= '0;
            r_high   <= '0;
            r_type   <= '0;
            r_mr     <= '0;
            r_digits <= '0;
            r_pid    <= '0;
            r_dcs    <= '0;
            r_udl    <= '0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_next   <= n_next;
            r_exp    <= n_exp;
            r_high   <= n_high;
            r_type   <= n_type;
            r_mr     <= n_mr;
            r_digits <= n_digits;
            r_pid    <= n_pid;
            r_dcs    <= n_dcs;
            r_udl    <= n_udl;
            r_err    <= n_err;
        end
    end

endmodule

@@ sv/sspp_out_stage.sv @@
module sspp_out_stage
    import sspp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_sspp_out i_res,
    output logic      o_space,
    output logic      o_valid,
    output t_sspp_out o_data,
    input  logic      i_ready
);

    logic      r_valid;
    t_sspp_out r_data;

    // Room for a result when empty or when the held beat leaves this cycle
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

endmodule

@@ sv/sms_submit_pdu_hex_parser.sv @@
// SMS-SUBMIT PDU header parser. Feed the PDU as ASCII hex characters, one per beat, with
// last set on the final one; each final character yields one result beat with the header
// octets, the status-report and header-present flags, and valid_res when every header
// character was hex and the total length matched the one implied by the user-data length
// and coding scheme. One character is taken every cycle but for the stall below: an input
// register feeds a single pass of decode and counter logic, and a result is loaded into
// the result register when its final character is taken from the input register. Input
// stalls only while a final character waits for the result register to be emptied. Streams
// longer than 2047 characters report invalid.
module sms_submit_pdu_hex_parser
    import sspp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_sspp_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_sspp_out o_out_data
);

    logic      w_item_valid;
    t_sspp_in  w_item;
    logic      w_take;
    logic      w_res_space;
    logic      w_res_load;
    t_sspp_out w_res;

    sspp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .o_ready      (o_in_ready),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    sspp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .i_res_space  (w_res_space),
        .o_take       (w_take),
        .o_res_load   (w_res_load),
        .o_res        (w_res)
    );

    sspp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_load),
        .i_res   (w_res),
        .o_space (w_res_space),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule

@@ sv/sspp_chk.sv @@
module sspp_chk
    import sspp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_sspp_in  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_sspp_out o_out_data
);

    // A stalled result beat holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Input never stalls while the result side has room
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with result room available");

    // Status report is only flagged on a valid PDU
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status_report_requested |-> o_out_data.valid_res)
        else $error("status report flagged on invalid PDU");

    // Reset empties the result register
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sms_submit_pdu_hex_parser sspp_chk u_sspp_chk (.*);

@@ verif/tb.sv @@
module tb;
    import sspp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_CHARS   = 750;
    localparam int RANDOM_RESULTS = 48;
    localparam int DRAIN_CYCLES   = 10;

    // Where the parser stands inside the PDU text
    typedef enum logic [3:0] {
        ST_SCA_LEN,
        ST_SCA_SKIP,
        ST_TYPE,
        ST_MR,
        ST_OA_LEN,
        ST_OA_SKIP,
        ST_PID,
        ST_DCS,
        ST_UDL,
        ST_DATA
    } t_parse_phase;

    // Hex character case used when building PDU text
    typedef enum int {
        CASE_UPPER,
        CASE_LOWER,
        CASE_MIXED
    } t_hex_case;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_sspp_in  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_sspp_out out_beat;

    sms_submit_pdu_hex_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    // Header parser mirror
    int unsigned  parse_pos;
    int unsigned  field_end;
    int unsigned  want_end;
    logic [3:0]   nib_hi;
    t_parse_phase phase;
    logic [7:0]   cap_type;
    logic [7:0]   cap_ref;
    logic [7:0]   cap_digits;
    logic [7:0]   cap_pid;
    logic [7:0]   cap_scheme;
    logic [7:0]   cap_udl;
    bit           bad_seen;

    t_sspp_out pending_results[$];

    int err_count    = 0;
    int results_seen = 0;
    int chars_sent   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int hold_request = 0;

    t_hex_case  hex_case = CASE_UPPER;
    logic [7:0] pdu_text[$];
    int         hdr_index[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit decode_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_parser();
        parse_pos  = 0;
        field_end  = 0;
        want_end   = 0;
        nib_hi     = 4'h0;
        phase      = ST_SCA_LEN;
        cap_type   = 8'h00;
        cap_ref    = 8'h00;
        cap_digits = 8'h00;
        cap_pid    = 8'h00;
        cap_scheme = 8'h00;
        cap_udl    = 8'h00;
        bad_seen   = 1'b0;
    endtask

    // Advance the mirror by one accepted character; queue a result on last
    task automatic predict_char(input t_sspp_in b);
        int unsigned p;
        int unsigned u;
        int unsigned d;
        logic [3:0]  v;
        logic [7:0]  oct;
        t_sspp_out   r;
        p = parse_pos;
        if (p >= POS_MAX) begin
            bad_seen = 1'b1;
        end else begin
            case (phase)
                ST_SCA_SKIP: if (p + 1 >= field_end) phase = ST_TYPE;
                ST_OA_SKIP:  if (p + 1 >= field_end) phase = ST_PID;
                ST_DATA: ;
                default: begin
                    if (!decode_nibble(b.hex_char, v)) bad_seen = 1'b1;
                    if (p % 2 == 0) begin
                        nib_hi = v;
                    end else begin
                        oct = {nib_hi, v};
                        u   = oct;
                        case (phase)
                            ST_SCA_LEN: begin
                                if (u == 0) begin
                                    phase = ST_TYPE;
                                end else begin
                                    field_end = (p + 1 + 2 * u) & 32'h7FF;
                                    phase     = ST_SCA_SKIP;
                                end
                            end
                            ST_TYPE: begin
                                cap_type = oct;
                                phase    = ST_MR;
                            end
                            ST_MR: begin
                                cap_ref = oct;
                                phase   = ST_OA_LEN;
                            end
                            ST_OA_LEN: begin
                                // odd digit counts round up to a whole octet
                                cap_digits = oct;
                                field_end  = (p + 1 + u + (u & 1) + 2) & 32'h7FF;
                                phase      = ST_OA_SKIP;
                            end
                            ST_PID: begin
                                cap_pid = oct;
                                phase   = ST_DCS;
                            end
                            ST_DCS: begin
                                cap_scheme = oct;
                                phase      = ST_UDL;
                            end
                            ST_UDL: begin
                                cap_udl = oct;
                                if (cap_scheme == DCS_GSM7) d = 2 * u - 2 * (u / 8);
                                else d = 2 * u;
                                want_end = (p + 1 + d) & 32'h7FF;
                                phase    = ST_DATA;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
            parse_pos = p + 1;
        end
        if (b.last) begin
            r.valid_res = !bad_seen && phase == ST_DATA && parse_pos == want_end;
            r.type_octet              = cap_type;
            r.msg_ref                 = cap_ref;
            r.originator_digits       = cap_digits;
            r.protocol_id             = cap_pid;
            r.coding_scheme           = cap_scheme;
            r.user_data_length        = cap_udl;
            r.status_report_requested = r.valid_res && cap_type[TYPE_SRR_BIT];
            r.header_present          = cap_type[TYPE_UDHI_BIT];
            pending_results.push_back(r);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_sspp_out want;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no prediction waiting");
            end else begin
                want = pending_results.pop_front();
                check_field("valid_res", out_beat.valid_res, want.valid_res);
                check_field("type_octet", out_beat.type_octet, want.type_octet);
                check_field("msg_ref", out_beat.msg_ref, want.msg_ref);
                check_field("originator_digits", out_beat.originator_digits,
                            want.originator_digits);
                check_field("protocol_id", out_beat.protocol_id, want.protocol_id);
                check_field("coding_scheme", out_beat.coding_scheme, want.coding_scheme);
                check_field("user_data_length", out_beat.user_data_length,
                            want.user_data_length);
                check_field("status_report_requested", out_beat.status_report_requested,
                            want.status_report_requested);
                check_field("header_present", out_beat.header_present,
                            want.header_present);
            end
        end
    end

    // Result side: own stall pattern, plus long hold-offs on request
    initial begin : result_sink
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(4, 60);
                    mode     = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one character beat and hold it until accepted
    task automatic send_beat(input logic [7:0] c, input bit is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_beat  <= t_sspp_in'{hex_char: c, last: is_last};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        predict_char(t_sspp_in'{hex_char: c, last: is_last});
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (pdu_text[i]) send_beat(pdu_text[i], i == pdu_text.size() - 1);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_of(input logic [3:0] n);
        bit lower;
        lower = (hex_case == CASE_LOWER) || (hex_case == CASE_MIXED && $urandom_range(0, 1));
        if (n < 10) return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    task automatic push_octet(input logic [7:0] o);
        hdr_index.push_back(pdu_text.size());
        pdu_text.push_back(hex_of(o[7:4]));
        hdr_index.push_back(pdu_text.size());
        pdu_text.push_back(hex_of(o[3:0]));
    endtask

    task automatic push_filler(input int n);
        repeat (n) pdu_text.push_back(8'($urandom_range(0, 255)));
    endtask

    // Lay out a full SMS-SUBMIT text; len_adj shifts the number of user data characters
    task automatic build_pdu(input logic [7:0] sca_len, input logic [7:0] ptype,
                             input logic [7:0] mr, input logic [7:0] digits,
                             input logic [7:0] pid, input logic [7:0] dcs,
                             input logic [7:0] udl, input int len_adj);
        int u;
        int n;
        u = udl;
        pdu_text.delete();
        hdr_index.delete();
        push_octet(sca_len);
        push_filler(2 * int'(sca_len));
        push_octet(ptype);
        push_octet(mr);
        push_octet(digits);
        push_filler(int'(digits) + (int'(digits) & 1) + 2);
        push_octet(pid);
        push_octet(dcs);
        push_octet(udl);
        n = (dcs == DCS_GSM7) ? 2 * (u - u / 8) : 2 * u;
        n = n + len_adj;
        if (n < 0) n = 0;
        push_filler(n);
    endtask

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        do c = 8'($urandom_range(0, 255)); while (decode_nibble(c, v));
        return c;
    endfunction

    task automatic test_well_formed();
        hex_case = CASE_UPPER;
        build_pdu(8'd0, 8'h31, 8'h00, 8'd11, 8'h00, DCS_GSM7, 8'd10, 0);
        send_text();
        hex_case = CASE_LOWER;
        build_pdu(8'd7, 8'h71, 8'h5A, 8'd12, 8'h00, 8'h08, 8'd3, 0);
        send_text();
        hex_case = CASE_MIXED;
        build_pdu(8'd6, 8'h11, 8'hC3, 8'd9, 8'h7F, 8'h04, 8'd17, 0);
        send_text();
        // septet packing boundary around eight characters
        hex_case = CASE_UPPER;
        build_pdu(8'd0, 8'h01, 8'h01, 8'd4, 8'h00, DCS_GSM7, 8'd8, 0);
        send_text();
        build_pdu(8'd1, 8'h41, 8'h02, 8'd5, 8'h00, DCS_GSM7, 8'd7, 0);
        send_text();
    endtask

    task automatic test_field_extremes();
        hex_case = CASE_UPPER;
        build_pdu(8'd0, 8'h00, 8'h00, 8'd0, 8'h00, 8'h00, 8'd0, 0);
        send_text();
        hex_case = CASE_LOWER;
        build_pdu(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        send_text();
        hex_case = CASE_UPPER;
        build_pdu(8'd0, 8'h20, 8'h80, 8'd1, 8'h00, DCS_GSM7, 8'hFF, 0);
        send_text();
    endtask

    task automatic test_malformed();
        logic [7:0] bad_chars[6];
        bad_chars = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        hex_case = CASE_MIXED;
        // non-hex characters just outside each hex range, at header positions
        foreach (bad_chars[i]) begin
            build_pdu(8'd0, 8'h31, 8'h10 + 8'(i), 8'd10, 8'h00, DCS_GSM7, 8'd4, 0);
            pdu_text[hdr_index[(i * 3) % hdr_index.size()]] = bad_chars[i];
            send_text();
        end
        // stream ends right after the PDU type
        build_pdu(8'd0, 8'h75, 8'h33, 8'd10, 8'h00, DCS_GSM7, 8'd4, 0);
        while (pdu_text.size() > 4) void'(pdu_text.pop_back());
        send_text();
        // single character
        send_beat("0", 1'b1);
        // stream ends inside the service-centre address
        build_pdu(8'd7, 8'h31, 8'h44, 8'd10, 8'h00, DCS_GSM7, 8'd4, 0);
        while (pdu_text.size() > 6) void'(pdu_text.pop_back());
        send_text();
        // user data one character too long, then one too short
        build_pdu(8'd0, 8'h21, 8'h55, 8'd10, 8'h00, 8'h08, 8'd5, 1);
        send_text();
        build_pdu(8'd0, 8'h21, 8'h56, 8'd10, 8'h00, DCS_GSM7, 8'd5, -1);
        send_text();
    endtask

    task automatic test_overlong();
        hex_case = CASE_UPPER;
        // right up to saturation, then past it
        build_pdu(8'd0, 8'h21, 8'h01, 8'd20, 8'h00, 8'h08, 8'hFF, 0);
        push_filler(int'(POS_MAX) - pdu_text.size());
        send_text();
        build_pdu(8'd0, 8'h61, 8'h02, 8'd20, 8'h00, 8'h08, 8'hFF, 0);
        push_filler(2100 - pdu_text.size());
        send_text();
    endtask

    task automatic test_output_stall();
        hex_case = CASE_UPPER;
        hold_request = 400;
        // keep offering short PDUs while results are held back
        repeat (16) begin
            build_pdu(8'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0,
                      8'h00, DCS_GSM7, 8'd0, 0);
            send_text();
            send_beat("0", 1'b1);
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_pdus();
        int kind;
        int adj;
        int k;
        logic [7:0] sca_len;
        logic [7:0] digits;
        logic [7:0] dcs;
        logic [7:0] udl;
        while (chars_sent < RANDOM_CHARS || results_seen < RANDOM_RESULTS) begin
            kind     = $urandom_range(0, 99);
            hex_case = t_hex_case'($urandom_range(0, 2));
            sca_len  = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 12));
            digits   = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 20));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: dcs = DCS_GSM7;
                4, 5, 6:    dcs = 8'h08;
                default:    dcs = 8'($urandom_range(0, 255));
            endcase
            udl = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 24));
            adj = 0;
            if (kind >= 65 && kind < 78) begin
                adj = $urandom_range(1, 3);
                if ($urandom_range(0, 1)) adj = -adj;
            end
            build_pdu(sca_len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), digits,
                      8'($urandom_range(0, 255)), dcs, udl, adj);
            if (kind >= 78 && kind < 88) begin
                // drop the tail at a random point
                k = $urandom_range(1, pdu_text.size() - 1);
                while (pdu_text.size() > k) void'(pdu_text.pop_back());
            end else if (kind >= 88 && kind < 95) begin
                pdu_text[hdr_index[$urandom_range(0, hdr_index.size() - 1)]] = pick_non_hex();
            end else if (kind >= 95) begin
                pdu_text.delete();
                push_filler($urandom_range(1, 24));
            end
            send_text();
        end
    endtask

    initial begin
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_well_formed();
        test_field_extremes();
        test_malformed();
        test_overlong();
        test_output_stall();
        test_random_pdus();
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
